// ===== hdl/pel_pkg.sv =====
package pel_pkg;

	localparam int CAPACITY = 16;
	localparam int WORD_W   = 32;
	localparam int POS_W    = 8;
	localparam int LEN_W    = 5;
	localparam int MODE_W   = 3;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef enum logic [MODE_W-1:0] {
		MODE_ADD_FRONT = 3'd0,
		MODE_ADD_BACK  = 3'd1,
		MODE_INSERT_AT = 3'd2,
		MODE_DEL_FRONT = 3'd3,
		MODE_DEL_BACK  = 3'd4,
		MODE_DEL_AT    = 3'd5,
		MODE_READ_AT   = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK    = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2,
		STAT_RANGE = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SHIFT,
		ST_INS_WR,
		ST_RDWAIT,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic signed [WORD_W-1:0] read_value;
		logic [LEN_W-1:0]         length;
		logic                     is_empty;
		status_t                  status;
	} res_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  waddr;
		logic [WORD_W-1:0] wdata;
		logic [IDX_W-1:0]  raddr;
	} ram_req_t;

endpackage

// ===== hdl/pel_in_if.sv =====
interface pel_in_if;
	import pel_pkg::*;

	logic                     valid;
	logic                     ready;
	logic [MODE_W-1:0]        mode;
	logic [POS_W-1:0]         position;
	logic signed [WORD_W-1:0] value;

	modport source (output valid, output mode, output position, output value, input ready);
	modport sink   (input valid, input mode, input position, input value, output ready);

endinterface

// ===== hdl/pel_out_if.sv =====
interface pel_out_if;
	import pel_pkg::*;

	logic                     valid;
	logic                     ready;
	logic signed [WORD_W-1:0] read_value;
	logic [LEN_W-1:0]         length;
	logic                     is_empty;
	logic [1:0]               status;

	modport source (output valid, output read_value, output length, output is_empty,
		output status, input ready);
	modport sink   (input valid, input read_value, input length, input is_empty,
		input status, output ready);

endinterface

// ===== hdl/pel_ram.sv =====
module pel_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 32,
	localparam int AW   = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/pel_ctrl.sv =====
module pel_ctrl (
	input  logic                     clk,
	input  logic                     arst_n,
	pel_in_if.sink                   req,
	output pel_pkg::res_t            res,
	output logic                     res_valid,
	input  logic                     res_take,
	output pel_pkg::ram_req_t        ram,
	input  logic [pel_pkg::WORD_W-1:0] ram_rdata
);
	import pel_pkg::*;

	state_t            state_q, state_n;
	logic [CNT_W-1:0]  count_q, count_n;
	logic [CNT_W-1:0]  cur_q, cur_n;
	logic [CNT_W-1:0]  idx_q, idx_n;
	logic              ins_q, ins_n;
	logic [WORD_W-1:0] word_q, word_n;
	logic [WORD_W-1:0] rdv_q, rdv_n;
	status_t           status_q, status_n;
	logic              wr_vld_s1, wr_vld_n;
	logic [IDX_W-1:0]  wr_addr_s1, wr_addr_n;

	logic             accept;
	logic             full, empty, past_end, more;
	logic [CNT_W-1:0] pos_cnt;

	assign accept   = req.valid && req.ready;
	assign full     = count_q == CNT_W'(CAPACITY);
	assign empty    = count_q == '0;
	assign past_end = CMP_W'(req.position) >= CMP_W'(count_q);
	assign pos_cnt  = CNT_W'(req.position);
	assign more     = ins_q ? (cur_q > idx_q) : (cur_q < count_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			count_q   <= '0;
			wr_vld_s1 <= 1'b0;
		end else begin
			state_q   <= state_n;
			count_q   <= count_n;
			wr_vld_s1 <= wr_vld_n;
		end
	end

	always_ff @(posedge clk) begin
		cur_q      <= cur_n;
		idx_q      <= idx_n;
		ins_q      <= ins_n;
		word_q     <= word_n;
		rdv_q      <= rdv_n;
		status_q   <= status_n;
		wr_addr_s1 <= wr_addr_n;
	end

	always_comb begin
		state_n   = state_q;
		count_n   = count_q;
		cur_n     = cur_q;
		idx_n     = idx_q;
		ins_n     = ins_q;
		word_n    = word_q;
		rdv_n     = rdv_q;
		status_n  = status_q;
		wr_vld_n  = 1'b0;
		wr_addr_n = wr_addr_s1;
		ram.raddr = IDX_W'(cur_q);
		req.ready = 1'b0;
		res_valid = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				req.ready = 1'b1;
				ram.raddr = IDX_W'(pos_cnt);
				if (accept) begin
					word_n   = req.value;
					rdv_n    = '0;
					status_n = STAT_OK;
					state_n  = ST_FINISH;
					case (mode_t'(req.mode))
						MODE_ADD_FRONT, MODE_ADD_BACK, MODE_INSERT_AT: begin
							if (full) begin
								status_n = STAT_FULL;
							end else begin
								ins_n   = 1'b1;
								cur_n   = count_q;
								state_n = ST_SHIFT;
								if (mode_t'(req.mode) == MODE_ADD_FRONT) begin
									idx_n = '0;
								end else if (mode_t'(req.mode) == MODE_ADD_BACK || past_end) begin
									idx_n = count_q;
								end else begin
									idx_n = pos_cnt;
								end
							end
						end
						MODE_DEL_FRONT, MODE_DEL_BACK, MODE_DEL_AT: begin
							if (empty) begin
								status_n = STAT_EMPTY;
							end else begin
								ins_n   = 1'b0;
								state_n = ST_SHIFT;
								if (mode_t'(req.mode) == MODE_DEL_FRONT) begin
									idx_n = '0;
								end else if (mode_t'(req.mode) == MODE_DEL_BACK || past_end) begin
									idx_n = count_q - 1'b1;
								end else begin
									idx_n = pos_cnt;
								end
								cur_n = idx_n + 1'b1;
							end
						end
						MODE_READ_AT: begin
							if (empty) begin
								status_n = STAT_EMPTY;
							end else if (past_end) begin
								status_n = STAT_RANGE;
							end else begin
								state_n = ST_RDWAIT;
							end
						end
						default: ;
					endcase
				end
			end
			ST_SHIFT: begin
				// reads run one entry ahead of the write-back, in the shift direction
				if (more) begin
					wr_vld_n = 1'b1;
					if (ins_q) begin
						ram.raddr = IDX_W'(cur_q - 1'b1);
						wr_addr_n = IDX_W'(cur_q);
						cur_n     = cur_q - 1'b1;
					end else begin
						ram.raddr = IDX_W'(cur_q);
						wr_addr_n = IDX_W'(cur_q - 1'b1);
						cur_n     = cur_q + 1'b1;
					end
				end else if (!wr_vld_s1) begin
					if (ins_q) begin
						state_n = ST_INS_WR;
					end else begin
						count_n = count_q - 1'b1;
						state_n = ST_FINISH;
					end
				end
			end
			ST_INS_WR: begin
				count_n = count_q + 1'b1;
				state_n = ST_FINISH;
			end
			ST_RDWAIT: begin
				rdv_n   = ram_rdata;
				state_n = ST_FINISH;
			end
			ST_FINISH: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_n = ST_IDLE;
				end
			end
			default: state_n = ST_IDLE;
		endcase

		ram.we    = wr_vld_s1 || (state_q == ST_INS_WR);
		ram.waddr = (state_q == ST_INS_WR) ? IDX_W'(idx_q) : wr_addr_s1;
		ram.wdata = (state_q == ST_INS_WR) ? word_q : ram_rdata;
	end

	assign res.read_value = rdv_q;
	assign res.length     = LEN_W'(count_q);
	assign res.is_empty   = count_q == '0;
	assign res.status     = status_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_write_state: assert property (@(posedge clk) disable iff (!arst_n)
		ram.we |-> (state_q == ST_SHIFT || state_q == ST_INS_WR))
		else $error("memory write outside a shift or insert");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("accepted word did not leave idle");

	a_write_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram.we |-> CNT_W'(ram.waddr) <= count_q)
		else $error("write beyond list end");

	a_shift_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SHIFT && state_n != ST_SHIFT) |-> !wr_vld_s1)
		else $error("left shift with a write pending");

endmodule

// ===== hdl/positional_list_engine.sv =====
// Positional list engine: an ordered list of up to CAPACITY signed 32-bit
// words held in one simple dual-port memory (one write, one registered read
// per cycle). Each request word carries an operation (add front/back, insert
// at, delete front/back, delete at, read at), a position and a value; each
// yields exactly one response word with the read value, the length after the
// operation, an empty flag and a status code. Positions at or past the
// length act on the back for adds and deletes; a read there reports a range
// status. Timing is set by the single memory read port, since an insert or
// delete moves every entry behind the target position one at a time and
// then waits for the last write-back to land. An insert then writes the new
// word, and a read waits for the registered memory data; a rejected or unused
// operation goes straight to the result. A full output register holds the
// result in the core until the register is free or draining.
// One request is in work at a time, but a new request is taken while the
// previous response still waits in the output register. The memory needs no
// clearing after reset: only entries below the length are ever read.
module positional_list_engine (
	input  logic      clk,
	input  logic      arst_n,
	pel_in_if.sink    req,
	pel_out_if.source rsp
);
	import pel_pkg::*;

	res_t              res;
	logic              res_valid;
	logic              res_take;
	ram_req_t          ram;
	logic [WORD_W-1:0] ram_rdata;

	logic out_valid_q;
	res_t out_q;

	pel_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.res       (res),
		.res_valid (res_valid),
		.res_take  (res_take),
		.ram       (ram),
		.ram_rdata (ram_rdata)
	);

	pel_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram.we),
		.waddr (ram.waddr),
		.wdata (ram.wdata),
		.raddr (ram.raddr),
		.rdata (ram_rdata)
	);

	// take the finished result when the output register is free or draining
	assign res_take = res_valid && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// hold the response payload until the sink takes it
	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_value = out_q.read_value;
	assign rsp.length     = out_q.length;
	assign rsp.is_empty   = out_q.is_empty;
	assign rsp.status     = out_q.status;

endmodule
